// ===== design/bced_pkg.sv =====
// shared types and constants for the button click event detector
// no dependencies
`default_nettype none

package bced_pkg;

    localparam int TICK_BITS = 16;
    localparam int CMP_W     = (TICK_BITS > 16) ? TICK_BITS : 16;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W     = $clog2(FIFO_DEPTH);
    localparam int LVL_W     = $clog2(FIFO_DEPTH + 1);

    typedef logic [TICK_BITS-1:0] tick_t;
    typedef logic [CMP_W-1:0]     cmp_t;
    typedef logic [PTR_W-1:0]     ptr_t;
    typedef logic [LVL_W-1:0]     lvl_t;

    // event codes
    localparam logic [2:0] EV_DOWN       = 3'd0;
    localparam logic [2:0] EV_UP         = 3'd1;
    localparam logic [2:0] EV_REPEAT     = 3'd2;
    localparam logic [2:0] EV_SINGLE     = 3'd3;
    localparam logic [2:0] EV_DOUBLE     = 3'd4;
    localparam logic [2:0] EV_LONG_START = 3'd5;
    localparam logic [2:0] EV_LONG_HOLD  = 3'd6;

    // register indexes
    localparam logic [2:0] REG_ACTIVE   = 3'd0;
    localparam logic [2:0] REG_DEBOUNCE = 3'd1;
    localparam logic [2:0] REG_SHORT    = 3'd2;
    localparam logic [2:0] REG_LONG     = 3'd3;
    localparam logic [2:0] REG_ENABLE   = 3'd4;

    // register reset values
    localparam logic        ACTIVE_RESET   = 1'b0;
    localparam logic [7:0]  DEBOUNCE_RESET = 8'd3;
    localparam logic [15:0] SHORT_RESET    = 16'd60;
    localparam logic [15:0] LONG_RESET     = 16'd200;
    localparam logic [6:0]  ENABLE_RESET   = 7'h7f;

    typedef struct packed {
        logic        press_level;
        logic [7:0]  debounce_len;
        logic [15:0] short_limit;
        logic [15:0] long_limit;
        logic [6:0]  event_enable;
    } cfg_t;

    // events of one tick after masking, in order
    typedef struct packed {
        logic [1:0] count;
        logic [2:0] code0;
        logic [2:0] code1;
    } push_t;

    typedef struct packed {
        logic [2:0] code;
        logic       last;
    } entry_t;

endpackage

`default_nettype wire

// ===== design/button_click_event_detector_top.sv =====
// button click event detector: debounce, press state machine, event queue
// throughput: one sample per cycle while in_stall is low; events of an accepted
// sample enter the event queue; a tick with two events needs two output transfers
// in_stall is high while the four-entry event queue holds more than two events
// reset: asynchronous active-low rst_n clears the phase, counters and queue,
// loads register defaults and sets the stable level to the inactive level
`default_nettype none

module button_click_event_detector_top
    import bced_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // apb-style configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // sample channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        pin_sample,
    // event channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       event_code,
    output logic             last
);

    cfg_t   cfg;
    push_t  push;
    entry_t head;
    lvl_t   level;
    logic   take;

    // a sample transfer completes on valid with no stall
    assign take = in_valid && !in_stall;

    // room is kept for the worst case of two events per tick
    assign in_stall = (level > lvl_t'(FIFO_DEPTH - 2));

    bced_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // debounce plus state machine, updated once per accepted sample
    bced_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .take       (take),
        .pin_sample (pin_sample),
        .push       (push)
    );

    // queued events leave one per output transfer
    bced_evq u_evq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (!out_stall),
        .head      (head),
        .not_empty (out_valid),
        .level     (level)
    );

    assign event_code = head.code;
    assign last       = head.last;

`ifndef SYNTH
    // queue never overfills
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= lvl_t'(FIFO_DEPTH))
        else $error("event queue level out of range");

    // the second event of a tick is already queued behind the first
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid)
        else $error("second event of a tick missing");

    // only defined event codes are offered
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> event_code != 3'd7)
        else $error("undefined event code on output");
`endif

endmodule

`default_nettype wire

// ===== design/bced_cfg.sv =====
// configuration register file behind the apb-style port
// depends on bced_pkg
`default_nettype none

module bced_cfg
    import bced_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output cfg_t             cfg
);

    cfg_t       cfg_reg;
    logic [2:0] idx;
    logic       wr_en;

    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.press_level  <= ACTIVE_RESET;
            cfg_reg.debounce_len <= DEBOUNCE_RESET;
            cfg_reg.short_limit  <= SHORT_RESET;
            cfg_reg.long_limit   <= LONG_RESET;
            cfg_reg.event_enable <= ENABLE_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_ACTIVE:   cfg_reg.press_level  <= pwdata[0];
                REG_DEBOUNCE: cfg_reg.debounce_len <= pwdata[7:0];
                REG_SHORT:    cfg_reg.short_limit  <= pwdata[15:0];
                REG_LONG:     cfg_reg.long_limit   <= pwdata[15:0];
                REG_ENABLE:   cfg_reg.event_enable <= pwdata[6:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_ACTIVE:   prdata = {31'd0, cfg_reg.press_level};
            REG_DEBOUNCE: prdata = {24'd0, cfg_reg.debounce_len};
            REG_SHORT:    prdata = {16'd0, cfg_reg.short_limit};
            REG_LONG:     prdata = {16'd0, cfg_reg.long_limit};
            REG_ENABLE:   prdata = {25'd0, cfg_reg.event_enable};
            default:      prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// ===== design/bced_core.sv =====
// debounce and press state machine, one tick per accepted sample
// depends on bced_pkg
`default_nettype none

module bced_core
    import bced_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire logic take,
    input  wire logic pin_sample,
    output push_t     push
);

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_PRESSED = 3'd1,
        PH_WAIT    = 3'd2,
        PH_REPEAT  = 3'd3,
        PH_LONG    = 3'd5
    } phase_t;

    phase_t     phase_reg, phase_next;
    tick_t      tick_reg, tick_next, tick_inc;
    logic [7:0] bounce_reg, bounce_next, bounce_inc;
    logic       stable_reg, stable_next;
    logic [3:0] repeats_reg, repeats_next;
    logic       pressed;
    logic       v0, v1;
    logic [2:0] c0, c1;
    logic       e0, e1;
    cmp_t       tick_w, short_w, long_w;

    always_comb
    begin
        // tick counter saturates
        tick_inc = tick_reg;
        if (phase_reg != PH_IDLE && tick_reg != '1)
            tick_inc = tick_reg + tick_t'(1);

        // run-length debounce
        stable_next = stable_reg;
        bounce_inc  = bounce_reg;
        bounce_next = 8'd0;
        if (pin_sample != stable_reg)
        begin
            if (bounce_reg != 8'hff)
                bounce_inc = bounce_reg + 8'd1;
            bounce_next = bounce_inc;
            if (bounce_inc >= cfg.debounce_len)
            begin
                stable_next = pin_sample;
                bounce_next = 8'd0;
            end
        end

        pressed = (stable_next == cfg.press_level);
        tick_w  = cmp_t'(tick_inc);
        short_w = cmp_t'(cfg.short_limit);
        long_w  = cmp_t'(cfg.long_limit);

        phase_next   = phase_reg;
        tick_next    = tick_inc;
        repeats_next = repeats_reg;
        v0 = 1'b0;
        v1 = 1'b0;
        c0 = EV_DOWN;
        c1 = EV_REPEAT;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (pressed)
                begin
                    v0 = 1'b1;
                    c0 = EV_DOWN;
                    tick_next    = '0;
                    repeats_next = 4'd1;
                    phase_next   = PH_PRESSED;
                end
            end
            PH_PRESSED:
            begin
                if (!pressed)
                begin
                    v0 = 1'b1;
                    c0 = EV_UP;
                    tick_next  = '0;
                    phase_next = PH_WAIT;
                end
                else if (tick_w > long_w)
                begin
                    v0 = 1'b1;
                    c0 = EV_LONG_START;
                    phase_next = PH_LONG;
                end
            end
            PH_WAIT:
            begin
                if (pressed)
                begin
                    v0 = 1'b1;
                    c0 = EV_DOWN;
                    v1 = 1'b1;
                    c1 = EV_REPEAT;
                    if (repeats_reg != 4'hf)
                        repeats_next = repeats_reg + 4'd1;
                    tick_next  = '0;
                    phase_next = PH_REPEAT;
                end
                else if (tick_w > short_w)
                begin
                    if (repeats_reg == 4'd1)
                    begin
                        v0 = 1'b1;
                        c0 = EV_SINGLE;
                    end
                    else if (repeats_reg == 4'd2)
                    begin
                        v0 = 1'b1;
                        c0 = EV_DOUBLE;
                    end
                    phase_next = PH_IDLE;
                end
            end
            PH_REPEAT:
            begin
                if (!pressed)
                begin
                    v0 = 1'b1;
                    c0 = EV_UP;
                    if (tick_w < short_w)
                    begin
                        tick_next  = '0;
                        phase_next = PH_WAIT;
                    end
                    else
                        phase_next = PH_IDLE;
                end
                else if (tick_w > short_w)
                    phase_next = PH_IDLE;
            end
            PH_LONG:
            begin
                v0 = 1'b1;
                if (pressed)
                    c0 = EV_LONG_HOLD;
                else
                begin
                    c0 = EV_UP;
                    phase_next = PH_IDLE;
                end
            end
            default:
                phase_next = PH_IDLE;
        endcase

        // suppress masked events, compact the rest
        e0 = v0 && cfg.event_enable[c0];
        e1 = v1 && cfg.event_enable[c1];
        push.count = take ? (2'(e0) + 2'(e1)) : 2'd0;
        push.code0 = e0 ? c0 : c1;
        push.code1 = c1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            tick_reg    <= '0;
            bounce_reg  <= 8'd0;
            stable_reg  <= ~ACTIVE_RESET;
            repeats_reg <= 4'd0;
        end
        else if (take)
        begin
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            bounce_reg  <= bounce_next;
            stable_reg  <= stable_next;
            repeats_reg <= repeats_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/bced_evq.sv =====
// small event queue that holds results until the output side takes them
// depends on bced_pkg
`default_nettype none

module bced_evq
    import bced_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire push_t push,
    input  wire logic  pop,
    output entry_t     head,
    output logic       not_empty,
    output lvl_t       level
);

    entry_t mem_reg [FIFO_DEPTH];
    ptr_t   wr_ptr_reg, rd_ptr_reg;
    lvl_t   level_reg;
    logic   pop_ok;

    assign pop_ok    = pop && (level_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign not_empty = (level_reg != '0);
    assign level     = level_reg;

    always_ff @(posedge clk)
    begin
        if (push.count == 2'd1)
            mem_reg[wr_ptr_reg] <= '{code: push.code0, last: 1'b1};
        else if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_reg]             <= '{code: push.code0, last: 1'b0};
            mem_reg[wr_ptr_reg + ptr_t'(1)] <= '{code: push.code1, last: 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + ptr_t'(push.count);
            if (pop_ok)
                rd_ptr_reg <= rd_ptr_reg + ptr_t'(1);
            level_reg <= level_reg + lvl_t'(push.count) - lvl_t'(pop_ok);
        end
    end

endmodule

`default_nettype wire
